### src/bfknn_pkg.sv
// Shared widths, codes and limits of the brute-force k-NN vector index.
package bfknn_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int DIM_MAX   = 64;
    localparam int K_MAX     = 16;

    localparam int ELEM_W    = 16;
    localparam int LABEL_W   = 31;
    localparam int DIST_W    = 40;
    localparam int KEY_W     = 41;
    localparam int SUM_W     = 42;
    localparam int PROD_W    = 34;
    localparam int ROWS_W    = 11;
    localparam int ROW_IDX_W = 10;
    localparam int POS_W     = 6;
    localparam int DIM_W     = 7;
    localparam int K_W       = 5;
    localparam int VADDR_W   = ROW_IDX_W + POS_W;

    typedef logic [1:0] req_t;
    localparam req_t REQ_APPEND = 2'd0;
    localparam req_t REQ_REMOVE = 2'd1;
    localparam req_t REQ_UPDATE = 2'd2;
    localparam req_t REQ_QUERY  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_NOT_FOUND = 2'd1;
    localparam status_t STAT_FULL      = 2'd2;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_DIM    = 2'd0;
    localparam cfg_idx_t CFG_METRIC = 2'd1;
    localparam cfg_idx_t CFG_K      = 2'd2;

    localparam logic signed [SUM_W-1:0] ACC_HI = 42'sh07F_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] ACC_LO = 42'sh380_0000_0000;
    localparam logic [DIST_W-1:0] EMPTY_DIST   = 40'hFF_FFFF_0000;
    localparam logic [31:0] NO_LABEL           = 32'hFFFF_FFFF;

endpackage

### src/bfknn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfknn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/brute_force_knn_vector_index.sv
// Top level of the labelled vector store with exact top-k search.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata element,target_label; tuser req_type;
//          |     |                    | tlast ends a vector
//  m_      | out | m_tvalid/m_tready  | tdata status,result_label,distance,removed,
//          |     |                    | rows_in_use; tlast ends a request's results
//  cfg_    | in  | cfg_we             | cfg_index selects register, cfg_data value
//
//  One input word is taken at a time; s_tready is high only while the sequencer idles.
//  Append/update/query element: S_IDLE then S_WRITE; a vector end zero-fills the rest of
//  its row. Update start: label scan over the stored rows. Remove: label scan over every
//  row plus an element-by-element copy of each row moved down. Query end: every row through
//  the one multiply-accumulate unit, then k result words. No clearing pass after reset.
//  The output register lets a word wait on m_tready while the next input is taken.
module brute_force_knn_vector_index
    import bfknn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // [15:0] element, [46:16] target_label, [47] zero
    input  logic [1:0]   s_tuser,   // [1:0] req_type
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // [1:0] status, [33:2] result_label, [73:34] distance,
                                    // [74] removed, [85:75] rows_in_use, [87:86] zero
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_UPD_RD, S_UPD_CHK, S_WRITE, S_ZFILL, S_FINISH, S_EMIT,
        S_RM_RD, S_RM_CHK, S_RM_CPRD, S_RM_CPWR, S_RM_LAB, S_RM_DONE,
        S_Q_ROW, S_Q_MAC, S_Q_INS, S_Q_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [DIM_W-1:0] vdim_reg;
    logic             metric_reg;
    logic [K_W-1:0]   nk_reg;
    logic [DIM_W-1:0] dim_eff;
    logic [K_W-1:0]   k_eff;
    logic [K_W-1:0]   k_m1;

    // stream and store bookkeeping
    logic [ROWS_W-1:0]  row_count_reg;
    logic [LABEL_W-1:0] next_label_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_cur_reg;
    req_t               kind_reg;
    logic [ROWS_W-1:0]  update_row_reg;
    logic [LABEL_W-1:0] upd_label_reg;

    // latched input word
    req_t               req_reg;
    logic [ELEM_W-1:0]  elem_reg;
    logic [LABEL_W-1:0] tl_reg;
    logic               last_reg;

    // scan counters
    logic [ROWS_W-1:0]  r_reg;
    logic [ROWS_W-1:0]  w_reg;
    logic [POS_W-1:0]   e_reg;
    logic [LABEL_W-1:0] lab_hold_reg;

    // pending single result
    status_t     em_status_reg;
    logic [31:0] em_label_reg;
    logic        em_removed_reg;

    // multiply-accumulate
    logic [DIM_W-1:0]           ie_reg;
    logic                       s1_v_reg;
    logic                       s2_v_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DIST_W-1:0]   acc_reg;

    // top-k list, kept sorted by key
    logic signed [KEY_W-1:0] best_d_reg [K_MAX];
    logic [LABEL_W-1:0]      best_l_reg [K_MAX];
    logic [K_W-1:0]          filled_reg;
    logic [K_W-1:0]          j_reg;

    // output register
    logic              m_tvalid_reg;
    status_t           out_status_reg;
    logic [31:0]       out_label_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              out_removed_reg;
    logic [ROWS_W-1:0] out_rows_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              out_load;

    // RAM ports
    logic               vec_we, vec_re;
    logic [VADDR_W-1:0] vec_waddr, vec_raddr;
    logic [ELEM_W-1:0]  vec_wdata, vec_rdata;
    logic               lab_we, lab_re;
    logic [ROW_IDX_W-1:0] lab_waddr, lab_raddr;
    logic [LABEL_W-1:0] lab_wdata, lab_rdata;
    logic               q_we, q_re;
    logic [POS_W-1:0]   q_waddr, q_raddr;
    logic [ELEM_W-1:0]  q_wdata, q_rdata;

    logic               s_fire;
    req_t               in_req;
    logic [POS_W-1:0]   pos_eff;
    logic               dst_ok;
    logic [ROW_IDX_W-1:0] wr_row;
    logic               issuing;
    logic signed [ELEM_W:0]   diff;
    logic signed [ELEM_W:0]   mul_a, mul_b;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] acc_clamped;
    logic signed [KEY_W-1:0]  key;
    logic [K_MAX-1:0]         ge;
    logic                     ins_ok;
    logic signed [KEY_W-1:0]  sel_d;
    logic signed [KEY_W-1:0]  sel_d_neg;

    assign dim_eff = (vdim_reg == '0) ? DIM_W'(1)
                   : ((vdim_reg > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : vdim_reg);
    assign k_eff   = (nk_reg == '0) ? K_W'(1)
                   : ((nk_reg > K_W'(K_MAX)) ? K_W'(K_MAX) : nk_reg);
    assign k_m1    = k_eff - K_W'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_req   = s_tuser;
    assign pos_eff  = (pos_reg != '0 && kind_reg != in_req) ? '0 : pos_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    // a new word goes into the output register this cycle
    assign out_load = ((state_reg == S_EMIT) || (state_reg == S_Q_OUT)) && out_free;

    // where the current vector lands, if anywhere
    always_comb
    begin
        dst_ok = 1'b0;
        unique case (req_reg)
            REQ_APPEND: dst_ok = (row_count_reg < ROWS_W'(MAX_ROWS));
            REQ_UPDATE: dst_ok = (update_row_reg < row_count_reg);
            REQ_QUERY:  dst_ok = 1'b1;
            REQ_REMOVE: dst_ok = 1'b0;
        endcase
    end
    assign wr_row = (req_reg == REQ_APPEND) ? row_count_reg[ROW_IDX_W-1:0]
                                            : update_row_reg[ROW_IDX_W-1:0];

    // shared multiply: difference squared, or plain product
    assign issuing = (ie_reg < dim_eff);
    assign diff    = {q_rdata[ELEM_W-1], q_rdata} - {vec_rdata[ELEM_W-1], vec_rdata};
    assign mul_a   = metric_reg ? {q_rdata[ELEM_W-1], q_rdata} : diff;
    assign mul_b   = metric_reg ? {vec_rdata[ELEM_W-1], vec_rdata} : diff;
    assign sum     = SUM_W'(acc_reg) + SUM_W'(prod_reg);
    always_comb
    begin
        priority if (sum > ACC_HI)
        begin
            acc_clamped = ACC_HI[DIST_W-1:0];
        end
        else if (sum < ACC_LO)
        begin
            acc_clamped = ACC_LO[DIST_W-1:0];
        end
        else
        begin
            acc_clamped = sum[DIST_W-1:0];
        end
    end
    // smaller key ranks first
    assign key = metric_reg ? -KEY_W'(acc_reg) : KEY_W'(acc_reg);

    // insertion point: first slot whose key is strictly larger, or the first free one
    always_comb
    begin
        for (int i = 0; i < K_MAX; i++)
        begin
            ge[i] = (K_W'(i) >= filled_reg) || (key < best_d_reg[i]);
        end
    end
    assign ins_ok = ge[k_m1[$clog2(K_MAX)-1:0]];

    assign sel_d     = best_d_reg[j_reg[$clog2(K_MAX)-1:0]];
    assign sel_d_neg = -sel_d;

    // RAM port control
    always_comb
    begin
        vec_we    = 1'b0;
        vec_waddr = {wr_row, pos_cur_reg};
        vec_wdata = elem_reg;
        vec_re    = 1'b0;
        vec_raddr = {r_reg[ROW_IDX_W-1:0], ie_reg[POS_W-1:0]};
        lab_we    = 1'b0;
        lab_waddr = row_count_reg[ROW_IDX_W-1:0];
        lab_wdata = next_label_reg;
        lab_re    = 1'b0;
        lab_raddr = r_reg[ROW_IDX_W-1:0];
        q_we      = 1'b0;
        q_waddr   = pos_cur_reg;
        q_wdata   = elem_reg;
        q_re      = 1'b0;
        q_raddr   = ie_reg[POS_W-1:0];
        unique case (state_reg)
            S_WRITE:
            begin
                vec_we = dst_ok && (req_reg != REQ_QUERY);
                q_we   = (req_reg == REQ_QUERY);
            end
            S_ZFILL:
            begin
                vec_we    = (req_reg != REQ_QUERY);
                vec_waddr = {wr_row, e_reg};
                vec_wdata = '0;
                q_we      = (req_reg == REQ_QUERY);
                q_waddr   = e_reg;
                q_wdata   = '0;
            end
            S_FINISH:
            begin
                lab_we = (req_reg == REQ_APPEND) && dst_ok;
            end
            S_UPD_RD, S_RM_RD, S_Q_ROW:
            begin
                lab_re = 1'b1;
            end
            S_RM_CPRD:
            begin
                vec_re    = 1'b1;
                vec_raddr = {r_reg[ROW_IDX_W-1:0], e_reg};
            end
            S_RM_CPWR:
            begin
                vec_we    = 1'b1;
                vec_waddr = {w_reg[ROW_IDX_W-1:0], e_reg};
                vec_wdata = vec_rdata;
            end
            S_RM_LAB:
            begin
                lab_we    = 1'b1;
                lab_waddr = w_reg[ROW_IDX_W-1:0];
                lab_wdata = lab_hold_reg;
            end
            S_Q_MAC:
            begin
                vec_re = issuing;
                q_re   = issuing;
            end
            default:
            begin
            end
        endcase
    end

    bfknn_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ROWS * DIM_MAX)) u_vec_ram (
        .clk(clk), .we(vec_we), .waddr(vec_waddr), .wdata(vec_wdata),
        .re(vec_re), .raddr(vec_raddr), .rdata(vec_rdata)
    );

    bfknn_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_ROWS)) u_lab_ram (
        .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
        .re(lab_re), .raddr(lab_raddr), .rdata(lab_rdata)
    );

    bfknn_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_MAX)) u_qry_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
    );

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_reg  <= in_req;
            elem_reg <= s_tdata[15:0];
            tl_reg   <= s_tdata[46:16];
            last_reg <= s_tlast;
        end
        if (state_reg == S_Q_MAC)
        begin
            if (s1_v_reg)
            begin
                prod_reg <= mul_a * mul_b;
            end
        end
        if (state_reg == S_Q_INS && ins_ok)
        begin
            if (ge[0])
            begin
                best_d_reg[0] <= key;
                best_l_reg[0] <= lab_rdata;
            end
            for (int i = 1; i < K_MAX; i++)
            begin
                if (ge[i])
                begin
                    if (!ge[i-1])
                    begin
                        best_d_reg[i] <= key;
                        best_l_reg[i] <= lab_rdata;
                    end
                    else
                    begin
                        best_d_reg[i] <= best_d_reg[i-1];
                        best_l_reg[i] <= best_l_reg[i-1];
                    end
                end
            end
        end
    end

    // sequencer, bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            vdim_reg        <= DIM_W'(DIM_MAX);
            metric_reg      <= 1'b0;
            nk_reg          <= K_W'(1);
            row_count_reg   <= '0;
            next_label_reg  <= '0;
            pos_reg         <= '0;
            pos_cur_reg     <= '0;
            kind_reg        <= REQ_APPEND;
            update_row_reg  <= '0;
            upd_label_reg   <= '0;
            r_reg           <= '0;
            w_reg           <= '0;
            e_reg           <= '0;
            lab_hold_reg    <= '0;
            em_status_reg   <= STAT_OK;
            em_label_reg    <= '0;
            em_removed_reg  <= 1'b0;
            ie_reg          <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            acc_reg         <= '0;
            filled_reg      <= '0;
            j_reg           <= '0;
            m_tvalid_reg    <= 1'b0;
            out_status_reg  <= STAT_OK;
            out_label_reg   <= '0;
            out_dist_reg    <= '0;
            out_removed_reg <= 1'b0;
            out_rows_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIM:    vdim_reg   <= cfg_data;
                    CFG_METRIC: metric_reg <= cfg_data[0];
                    CFG_K:      nk_reg     <= cfg_data[K_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        r_reg <= '0;
                        w_reg <= '0;
                        if (in_req == REQ_REMOVE)
                        begin
                            pos_reg   <= '0;
                            state_reg <= (row_count_reg == '0) ? S_RM_DONE : S_RM_RD;
                        end
                        else
                        begin
                            pos_cur_reg <= pos_eff;
                            if (pos_eff == '0)
                            begin
                                kind_reg <= in_req;
                            end
                            if (pos_eff == '0 && in_req == REQ_UPDATE)
                            begin
                                update_row_reg <= ROWS_W'(MAX_ROWS);
                                state_reg <= (row_count_reg == '0) ? S_WRITE : S_UPD_RD;
                            end
                            else
                            begin
                                state_reg <= S_WRITE;
                            end
                        end
                    end
                end

                S_UPD_RD:
                begin
                    state_reg <= S_UPD_CHK;
                end

                S_UPD_CHK:
                begin
                    if (lab_rdata == tl_reg)
                    begin
                        update_row_reg <= r_reg;
                        upd_label_reg  <= lab_rdata;
                        state_reg      <= S_WRITE;
                    end
                    else
                    begin
                        r_reg     <= r_reg + ROWS_W'(1);
                        state_reg <= (r_reg + ROWS_W'(1) == row_count_reg) ? S_WRITE
                                                                           : S_UPD_RD;
                    end
                end

                S_WRITE:
                begin
                    if (!last_reg && (DIM_W'(pos_cur_reg) + DIM_W'(1) < dim_eff))
                    begin
                        pos_reg   <= pos_cur_reg + POS_W'(1);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pos_reg <= '0;
                        // trailing elements of the row are cleared
                        if (dst_ok && pos_cur_reg != POS_W'(DIM_MAX - 1))
                        begin
                            e_reg     <= pos_cur_reg + POS_W'(1);
                            state_reg <= S_ZFILL;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                S_ZFILL:
                begin
                    e_reg <= e_reg + POS_W'(1);
                    if (e_reg == POS_W'(DIM_MAX - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    em_removed_reg <= 1'b0;
                    unique case (req_reg)
                        REQ_APPEND:
                        begin
                            if (dst_ok)
                            begin
                                em_status_reg  <= STAT_OK;
                                em_label_reg   <= {1'b0, next_label_reg};
                                row_count_reg  <= row_count_reg + ROWS_W'(1);
                                next_label_reg <= next_label_reg + LABEL_W'(1);
                            end
                            else
                            begin
                                em_status_reg <= STAT_FULL;
                                em_label_reg  <= NO_LABEL;
                            end
                            state_reg <= S_EMIT;
                        end
                        REQ_UPDATE:
                        begin
                            if (dst_ok)
                            begin
                                em_status_reg <= STAT_OK;
                                em_label_reg  <= {1'b0, upd_label_reg};
                            end
                            else
                            begin
                                em_status_reg <= STAT_NOT_FOUND;
                                em_label_reg  <= NO_LABEL;
                            end
                            state_reg <= S_EMIT;
                        end
                        REQ_QUERY:
                        begin
                            filled_reg <= '0;
                            j_reg      <= '0;
                            r_reg      <= '0;
                            state_reg  <= (row_count_reg == '0) ? S_Q_OUT : S_Q_ROW;
                        end
                        REQ_REMOVE:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg    <= 1'b1;
                        out_status_reg  <= em_status_reg;
                        out_label_reg   <= em_label_reg;
                        out_dist_reg    <= '0;
                        out_removed_reg <= em_removed_reg;
                        out_rows_reg    <= row_count_reg;
                        out_last_reg    <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end

                S_RM_RD:
                begin
                    state_reg <= S_RM_CHK;
                end

                S_RM_CHK:
                begin
                    if (lab_rdata == tl_reg)
                    begin
                        r_reg     <= r_reg + ROWS_W'(1);
                        state_reg <= (r_reg + ROWS_W'(1) == row_count_reg) ? S_RM_DONE
                                                                           : S_RM_RD;
                    end
                    else if (w_reg != r_reg)
                    begin
                        lab_hold_reg <= lab_rdata;
                        e_reg        <= '0;
                        state_reg    <= S_RM_CPRD;
                    end
                    else
                    begin
                        w_reg     <= w_reg + ROWS_W'(1);
                        r_reg     <= r_reg + ROWS_W'(1);
                        state_reg <= (r_reg + ROWS_W'(1) == row_count_reg) ? S_RM_DONE
                                                                           : S_RM_RD;
                    end
                end

                S_RM_CPRD:
                begin
                    state_reg <= S_RM_CPWR;
                end

                S_RM_CPWR:
                begin
                    e_reg     <= e_reg + POS_W'(1);
                    state_reg <= (e_reg == POS_W'(DIM_MAX - 1)) ? S_RM_LAB : S_RM_CPRD;
                end

                S_RM_LAB:
                begin
                    w_reg     <= w_reg + ROWS_W'(1);
                    r_reg     <= r_reg + ROWS_W'(1);
                    state_reg <= (r_reg + ROWS_W'(1) == row_count_reg) ? S_RM_DONE
                                                                       : S_RM_RD;
                end

                S_RM_DONE:
                begin
                    em_status_reg  <= STAT_OK;
                    em_label_reg   <= NO_LABEL;
                    em_removed_reg <= (w_reg != row_count_reg);
                    row_count_reg  <= w_reg;
                    state_reg      <= S_EMIT;
                end

                S_Q_ROW:
                begin
                    acc_reg   <= '0;
                    ie_reg    <= '0;
                    s1_v_reg  <= 1'b0;
                    s2_v_reg  <= 1'b0;
                    state_reg <= S_Q_MAC;
                end

                S_Q_MAC:
                begin
                    if (issuing)
                    begin
                        ie_reg <= ie_reg + DIM_W'(1);
                    end
                    s1_v_reg <= issuing;
                    s2_v_reg <= s1_v_reg;
                    if (s2_v_reg)
                    begin
                        acc_reg <= acc_clamped;
                    end
                    if (!issuing && !s1_v_reg && !s2_v_reg)
                    begin
                        state_reg <= S_Q_INS;
                    end
                end

                S_Q_INS:
                begin
                    if (ins_ok && filled_reg < k_eff)
                    begin
                        filled_reg <= filled_reg + K_W'(1);
                    end
                    r_reg     <= r_reg + ROWS_W'(1);
                    state_reg <= (r_reg + ROWS_W'(1) == row_count_reg) ? S_Q_OUT : S_Q_ROW;
                end

                S_Q_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg    <= 1'b1;
                        out_status_reg  <= STAT_OK;
                        out_removed_reg <= 1'b0;
                        out_rows_reg    <= row_count_reg;
                        out_last_reg    <= (j_reg + K_W'(1) == k_eff);
                        if (j_reg < filled_reg)
                        begin
                            out_label_reg <= {1'b0, best_l_reg[j_reg[$clog2(K_MAX)-1:0]]};
                            out_dist_reg  <= metric_reg ? sel_d_neg[DIST_W-1:0]
                                                        : sel_d[DIST_W-1:0];
                        end
                        else
                        begin
                            out_label_reg <= NO_LABEL;
                            out_dist_reg  <= EMPTY_DIST;
                        end
                        j_reg <= j_reg + K_W'(1);
                        if (j_reg + K_W'(1) == k_eff)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_rows_reg, out_removed_reg, out_dist_reg,
                       out_label_reg, out_status_reg};

endmodule
